/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define WPDM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wpdm assertion failed");

// Clocked assertion that also holds during reset.
`define WPDM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wpdm assertion failed");

`endif

/* hdl/wpdm_pkg.sv */
// Package with the types, codes and constants of the WAV parser and downmix block.
`timescale 1ns / 1ps
package wpdm_pkg;

  localparam int          FIFO_DEPTH_DEF = 4;
  localparam logic [31:0] MAX_RATE_RST   = 32'd384000;

  localparam logic [31:0] TAG_RIFF = 32'h46464952;
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT  = 32'h20746D66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  localparam logic [15:0] PCM_FORMAT    = 16'd1;
  localparam logic [15:0] PCM_BITS      = 16'd16;
  localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
  localparam logic [3:0]  FMT_LAST_IDX  = 4'd15;
  localparam logic [15:0] CH_MONO       = 16'd1;
  localparam logic [15:0] CH_STEREO     = 16'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int TDATA_W = 88;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_ID,
    PH_SZ_FMT,
    PH_SZ_DATA,
    PH_SZ_OTHER,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_HALT
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_RIFF_TAG   = 4'd1,
    ST_RIFF_SIZE  = 4'd2,
    ST_WAVE_TAG   = 4'd3,
    ST_CHUNK_SIZE = 4'd4,
    ST_FMT_SMALL  = 4'd5,
    ST_FMT_TRUNC  = 4'd6,
    ST_SKIP_TRUNC = 4'd7,
    ST_DATA_TRUNC = 4'd8,
    ST_NO_FMT     = 4'd9,
    ST_FMT_CODE   = 4'd10,
    ST_BITS       = 4'd11,
    ST_CHANNELS   = 4'd12,
    ST_RATE       = 4'd13,
    ST_ALIGN      = 4'd14
  } status_t;

  typedef struct packed {
    logic               kind;
    logic signed [16:0] mono_sample;
    status_t            status;
    logic [31:0]        rate_out;
    logic [1:0]         channels_out;
    logic [31:0]        frames_out;
    logic               last_result;
  } result_t;

  // Up to two results per input byte: a sample, then the final status.
  typedef struct packed {
    logic    sample_vld;
    logic    status_vld;
    result_t sample;
    result_t status;
  } push_t;

endpackage

/* hdl/wav_pcm16_parser_downmix_unit.sv */
// Top level of the WAV 16-bit PCM parser with mono downmix.
//
//   channel | direction | request moves
//   --------+-----------+-------------------------------------------------
//   in_     | slave     | one file byte, tlast on the last byte of the file
//   out_    | master    | one sample or, with tlast, the final status
//   cfg_    | write     | max_sample_rate, taken on any cycle with cfg_we
//
// One byte is taken per cycle while in_tready is high; its results are queued in the next cycle.
// A byte yields at most two results, so in_tready is high while the queue has room
// for two; with out_tready held high the block runs at one byte per cycle.
// Reset is synchronous and active low; it empties the queue and restarts the parser.
// A stall on the output side holds the head result and, once the queue fills, in_tready.
`timescale 1ns / 1ps
module wav_pcm16_parser_downmix_unit #(
  parameter int FIFO_DEPTH = wpdm_pkg::FIFO_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // file_byte[7:0]
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // mono_sample[16:0], status[20:17], rate_out[52:21], channels_out[54:53],
  // frames_out[86:55], zero [87]
  output logic [wpdm_pkg::TDATA_W-1:0] out_tdata,
  output logic                         out_tuser,  // kind[0]
  output logic                         out_tlast
);

  wpdm_pkg::push_t   push;
  wpdm_pkg::result_t res;
  logic              in_acc;

  assign in_acc = in_tvalid && in_tready;

  wpdm_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .in_byte   (in_tdata),
    .in_eof    (in_tlast),
    .push      (push)
  );

  wpdm_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {1'b0, res.frames_out, res.channels_out, res.rate_out, res.status,
                      res.mono_sample};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_result;

endmodule

/* hdl/wpdm_parser.sv */
// Byte-wise RIFF/WAVE chunk parser with fmt checks and mono downmix of 16-bit frames.
`timescale 1ns / 1ps
module wpdm_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_acc,
  input  logic [7:0]         in_byte,
  input  logic               in_eof,
  output wpdm_pkg::push_t    push
);

  logic [31:0]         max_rate_r;
  wpdm_pkg::phase_t    phase_r, phase_nxt;
  logic [31:0]         bc_r, bc_nxt;
  logic [31:0]         fs_r, fs_nxt;
  logic [32:0]         rem_r, rem_nxt;
  logic [15:0]         fc_r, fc_nxt;
  logic [15:0]         ch_r, ch_nxt;
  logic [31:0]         rate_r, rate_nxt;
  logic [15:0]         sb_r, sb_nxt;
  logic                seen_r, seen_nxt;
  logic                stereo_r, stereo_nxt;
  logic [1:0]          fp_r, fp_nxt;
  logic [31:0]         total_r, total_nxt;
  wpdm_pkg::status_t   err_r, err_nxt;

  wpdm_pkg::status_t   fin_err;
  logic [31:0]         fin_rate;
  logic [1:0]          fin_ch;
  logic [31:0]         fin_frames;

  logic [31:0]         word_w;
  logic [31:0]         data_w;
  logic [32:0]         rem_dec;
  logic [32:0]         word_rem;
  logic                frame_done;
  logic                sample_emit;
  logic signed [16:0]  sample_val;
  logic [3:0]          fmt_k;

  function automatic logic [31:0] lane_or(input logic [31:0] w, input logic [7:0] b,
                                          input logic [1:0] k);
    lane_or = w | ({24'd0, b} << {k, 3'b000});
  endfunction

  assign word_w     = lane_or(fs_r, in_byte, bc_r[1:0]);
  assign data_w     = lane_or(fs_r, in_byte, fp_r);
  assign rem_dec    = rem_r - 33'd1;
  assign word_rem   = {1'b0, word_w} + {32'd0, word_w[0]};
  assign fmt_k      = bc_r[3:0];
  assign frame_done = stereo_r ? (fp_r == 2'd3) : (fp_r != 2'd0);
  assign sample_emit = in_acc && (phase_r == wpdm_pkg::PH_DATA) && (bc_r != 32'd0)
                       && frame_done;
  assign sample_val = stereo_r ? ({data_w[15], data_w[15:0]} + {data_w[31], data_w[31:16]})
                               : {data_w[15:0], 1'b0};

  // Next-state logic.
  always_comb begin
    phase_nxt  = phase_r;
    bc_nxt     = bc_r;
    fs_nxt     = fs_r;
    rem_nxt    = rem_r;
    fc_nxt     = fc_r;
    ch_nxt     = ch_r;
    rate_nxt   = rate_r;
    sb_nxt     = sb_r;
    seen_nxt   = seen_r;
    stereo_nxt = stereo_r;
    fp_nxt     = fp_r;
    total_nxt  = total_r;
    err_nxt    = err_r;
    fin_err    = wpdm_pkg::ST_OK;
    fin_rate   = 32'd0;
    fin_ch     = 2'd0;
    fin_frames = 32'd0;
    if (in_acc) begin
      unique case (phase_r)
        wpdm_pkg::PH_RIFF, wpdm_pkg::PH_RSIZE, wpdm_pkg::PH_WAVE, wpdm_pkg::PH_ID,
        wpdm_pkg::PH_SZ_FMT, wpdm_pkg::PH_SZ_DATA, wpdm_pkg::PH_SZ_OTHER: begin
          fs_nxt = word_w;
          bc_nxt = {30'd0, bc_r[1:0]} + 32'd1;
          if (bc_r[1:0] == 2'd3) begin
            bc_nxt = 32'd0;
            fs_nxt = 32'd0;
            unique case (phase_r)
              wpdm_pkg::PH_RIFF: begin
                if (word_w == wpdm_pkg::TAG_RIFF) begin
                  phase_nxt = wpdm_pkg::PH_RSIZE;
                end else begin
                  err_nxt   = wpdm_pkg::ST_RIFF_TAG;
                  phase_nxt = wpdm_pkg::PH_HALT;
                end
              end
              wpdm_pkg::PH_RSIZE: begin
                phase_nxt = wpdm_pkg::PH_WAVE;
              end
              wpdm_pkg::PH_WAVE: begin
                if (word_w == wpdm_pkg::TAG_WAVE) begin
                  phase_nxt = wpdm_pkg::PH_ID;
                end else begin
                  err_nxt   = wpdm_pkg::ST_WAVE_TAG;
                  phase_nxt = wpdm_pkg::PH_HALT;
                end
              end
              wpdm_pkg::PH_ID: begin
                if (word_w == wpdm_pkg::TAG_FMT) begin
                  phase_nxt = wpdm_pkg::PH_SZ_FMT;
                end else if (word_w == wpdm_pkg::TAG_DATA) begin
                  phase_nxt = wpdm_pkg::PH_SZ_DATA;
                end else begin
                  phase_nxt = wpdm_pkg::PH_SZ_OTHER;
                end
              end
              wpdm_pkg::PH_SZ_FMT: begin
                if (word_w < wpdm_pkg::FMT_MIN_SIZE) begin
                  err_nxt   = wpdm_pkg::ST_FMT_SMALL;
                  phase_nxt = wpdm_pkg::PH_HALT;
                end else begin
                  rem_nxt   = word_rem;
                  fc_nxt    = 16'd0;
                  ch_nxt    = 16'd0;
                  rate_nxt  = 32'd0;
                  sb_nxt    = 16'd0;
                  phase_nxt = wpdm_pkg::PH_FMT;
                end
              end
              wpdm_pkg::PH_SZ_DATA: begin
                if (!seen_r) begin
                  err_nxt   = wpdm_pkg::ST_NO_FMT;
                  phase_nxt = wpdm_pkg::PH_HALT;
                end else if (stereo_r ? (word_w[1:0] != 2'd0) : word_w[0]) begin
                  err_nxt   = wpdm_pkg::ST_ALIGN;
                  phase_nxt = wpdm_pkg::PH_HALT;
                end else begin
                  rem_nxt   = word_rem;
                  bc_nxt    = word_w;
                  fp_nxt    = 2'd0;
                  phase_nxt = (word_rem != 33'd0) ? wpdm_pkg::PH_DATA : wpdm_pkg::PH_ID;
                end
              end
              default: begin
                rem_nxt   = word_rem;
                phase_nxt = (word_rem != 33'd0) ? wpdm_pkg::PH_SKIP : wpdm_pkg::PH_ID;
              end
            endcase
          end
        end
        wpdm_pkg::PH_FMT: begin
          if (fmt_k < 4'd2) begin
            fc_nxt = fc_r | ({8'd0, in_byte} << {fmt_k[0], 3'b000});
          end else if (fmt_k < 4'd4) begin
            ch_nxt = ch_r | ({8'd0, in_byte} << {fmt_k[0], 3'b000});
          end else if (fmt_k < 4'd8) begin
            rate_nxt = rate_r | ({24'd0, in_byte} << {fmt_k[1:0], 3'b000});
          end else if (fmt_k >= 4'd14) begin
            sb_nxt = sb_r | ({8'd0, in_byte} << {fmt_k[0], 3'b000});
          end
          bc_nxt  = bc_r + 32'd1;
          rem_nxt = rem_dec;
          if (fmt_k == wpdm_pkg::FMT_LAST_IDX) begin
            bc_nxt = 32'd0;
            priority if (fc_nxt != wpdm_pkg::PCM_FORMAT) begin
              err_nxt   = wpdm_pkg::ST_FMT_CODE;
              phase_nxt = wpdm_pkg::PH_HALT;
            end else if (sb_nxt != wpdm_pkg::PCM_BITS) begin
              err_nxt   = wpdm_pkg::ST_BITS;
              phase_nxt = wpdm_pkg::PH_HALT;
            end else if (ch_nxt != wpdm_pkg::CH_MONO && ch_nxt != wpdm_pkg::CH_STEREO) begin
              err_nxt   = wpdm_pkg::ST_CHANNELS;
              phase_nxt = wpdm_pkg::PH_HALT;
            end else if (rate_nxt == 32'd0 || rate_nxt > max_rate_r) begin
              err_nxt   = wpdm_pkg::ST_RATE;
              phase_nxt = wpdm_pkg::PH_HALT;
            end else begin
              seen_nxt   = 1'b1;
              stereo_nxt = (ch_nxt == wpdm_pkg::CH_STEREO);
              phase_nxt  = (rem_dec != 33'd0) ? wpdm_pkg::PH_SKIP : wpdm_pkg::PH_ID;
            end
          end
        end
        wpdm_pkg::PH_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == 33'd0) begin
            phase_nxt = wpdm_pkg::PH_ID;
          end
        end
        wpdm_pkg::PH_DATA: begin
          // Bytes past the declared size but inside the chunk are the pad byte.
          if (bc_r != 32'd0) begin
            bc_nxt = bc_r - 32'd1;
            if (frame_done) begin
              total_nxt = total_r + 32'd1;
              fp_nxt    = 2'd0;
              fs_nxt    = 32'd0;
            end else begin
              fp_nxt = fp_r + 2'd1;
              fs_nxt = data_w;
            end
          end
          rem_nxt = rem_dec;
          if (rem_dec == 33'd0) begin
            phase_nxt = wpdm_pkg::PH_ID;
            bc_nxt    = 32'd0;
            fs_nxt    = 32'd0;
          end
        end
        default: begin
        end
      endcase

      if (in_eof) begin
        fin_err = err_nxt;
        if (err_nxt == wpdm_pkg::ST_OK) begin
          unique case (phase_nxt)
            wpdm_pkg::PH_RIFF:  fin_err = wpdm_pkg::ST_RIFF_TAG;
            wpdm_pkg::PH_RSIZE: fin_err = wpdm_pkg::ST_RIFF_SIZE;
            wpdm_pkg::PH_WAVE:  fin_err = wpdm_pkg::ST_WAVE_TAG;
            wpdm_pkg::PH_SZ_FMT, wpdm_pkg::PH_SZ_DATA, wpdm_pkg::PH_SZ_OTHER:
              fin_err = wpdm_pkg::ST_CHUNK_SIZE;
            wpdm_pkg::PH_FMT:   fin_err = wpdm_pkg::ST_FMT_TRUNC;
            wpdm_pkg::PH_SKIP:  fin_err = wpdm_pkg::ST_SKIP_TRUNC;
            wpdm_pkg::PH_DATA: begin
              if (bc_nxt != 32'd0) begin
                fin_err = wpdm_pkg::ST_DATA_TRUNC;
              end
            end
            default: begin
            end
          endcase
          if (fin_err == wpdm_pkg::ST_OK && !seen_nxt) begin
            fin_err = wpdm_pkg::ST_NO_FMT;
          end
        end
        fin_frames = total_nxt;
        if (fin_err == wpdm_pkg::ST_OK) begin
          fin_rate = rate_nxt;
          fin_ch   = ch_nxt[1:0];
        end
        // The file is done: everything but the register goes back to reset.
        phase_nxt  = wpdm_pkg::PH_RIFF;
        bc_nxt     = 32'd0;
        fs_nxt     = 32'd0;
        rem_nxt    = 33'd0;
        fc_nxt     = 16'd0;
        ch_nxt     = 16'd0;
        rate_nxt   = 32'd0;
        sb_nxt     = 16'd0;
        seen_nxt   = 1'b0;
        stereo_nxt = 1'b0;
        fp_nxt     = 2'd0;
        total_nxt  = 32'd0;
        err_nxt    = wpdm_pkg::ST_OK;
      end
    end
  end

  // Result outputs.
  always_comb begin
    push                     = '0;
    push.sample_vld          = sample_emit;
    push.sample.kind         = wpdm_pkg::KIND_SAMPLE;
    push.sample.mono_sample  = sample_val;
    push.sample.status       = wpdm_pkg::ST_OK;
    push.sample.last_result  = 1'b0;
    push.status_vld          = in_acc && in_eof;
    push.status.kind         = wpdm_pkg::KIND_STATUS;
    push.status.mono_sample  = 17'sd0;
    push.status.status       = fin_err;
    push.status.rate_out     = fin_rate;
    push.status.channels_out = fin_ch;
    push.status.frames_out   = fin_frames;
    push.status.last_result  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rate_r <= wpdm_pkg::MAX_RATE_RST;
    end else if (cfg_we) begin
      max_rate_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wpdm_pkg::PH_RIFF;
      bc_r     <= 32'd0;
      fs_r     <= 32'd0;
      rem_r    <= 33'd0;
      fc_r     <= 16'd0;
      ch_r     <= 16'd0;
      rate_r   <= 32'd0;
      sb_r     <= 16'd0;
      seen_r   <= 1'b0;
      stereo_r <= 1'b0;
      fp_r     <= 2'd0;
      total_r  <= 32'd0;
      err_r    <= wpdm_pkg::ST_OK;
    end else begin
      phase_r  <= phase_nxt;
      bc_r     <= bc_nxt;
      fs_r     <= fs_nxt;
      rem_r    <= rem_nxt;
      fc_r     <= fc_nxt;
      ch_r     <= ch_nxt;
      rate_r   <= rate_nxt;
      sb_r     <= sb_nxt;
      seen_r   <= seen_nxt;
      stereo_r <= stereo_nxt;
      fp_r     <= fp_nxt;
      total_r  <= total_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

/* hdl/wpdm_out_fifo.sv */
// Result queue that takes up to two results per cycle and hands out one per request.
`timescale 1ns / 1ps
module wpdm_out_fifo #(
  parameter int DEPTH = wpdm_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wpdm_pkg::push_t    push,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output wpdm_pkg::result_t  out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wpdm_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  wr1;
  logic [CNT_W-1:0]  n_push;
  logic              pop;
  wpdm_pkg::result_t first;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign n_push    = CNT_W'(push.sample_vld) + CNT_W'(push.status_vld);
  assign pop       = out_valid && out_ready;
  assign wr1       = ptr_inc(wp_r);
  assign first     = push.sample_vld ? push.sample : push.status;
  // Room for a full pair of results is required before a byte is taken.
  assign space_ok  = (cnt_r <= CNT_W'(DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    if (n_push == CNT_W'(2)) begin
      wp_nxt = ptr_inc(wr1);
    end else if (n_push == CNT_W'(1)) begin
      wp_nxt = wr1;
    end
    rp_nxt  = pop ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.sample_vld || push.status_vld) begin
      mem[wp_r] <= first;
    end
    if (push.sample_vld && push.status_vld) begin
      mem[wr1] <= push.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hdl/wpdm_checker.sv */
// Port-level checker for the WAV parser top level, with its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wpdm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         in_tlast,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [wpdm_pkg::TDATA_W-1:0] out_tdata,
  input logic                         out_tuser,
  input logic                         out_tlast
);

  logic        out_stall;
  logic        eof_acc;
  logic        err_status;
  logic [33:0] fmt_info;

  assign out_stall  = out_tvalid && !out_tready;
  assign eof_acc    = in_tvalid && in_tready && in_tlast;
  assign err_status = out_tvalid && (out_tuser == wpdm_pkg::KIND_STATUS)
                      && (out_tdata[20:17] != wpdm_pkg::ST_OK);
  assign fmt_info   = out_tdata[54:21];

  // The queue is empty right after a reset cycle.
  `WPDM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)

  // A held result stays in place.
  `WPDM_ASSERT(a_stall_hold, clk, rst_n, out_stall |=> out_tvalid && $stable(out_tdata))

  // The last byte of a file always leaves a status result waiting.
  `WPDM_ASSERT(a_eof_status, clk, rst_n, eof_acc |=> out_tvalid)

  // A failed file reports neither rate nor channel count.
  `WPDM_ASSERT(a_err_no_fmt, clk, rst_n, err_status |-> (fmt_info == 34'd0))

  // Only the status result of a file carries tlast.
  `WPDM_ASSERT(a_last_status, clk, rst_n, out_tvalid |-> (out_tlast == out_tuser))

endmodule

bind wav_pcm16_parser_downmix_unit wpdm_checker u_wpdm_checker (.*);

/* tb/wav_downmix_checker.sv */
// Checker that predicts and compares the results of the WAV parser and downmix block.
`timescale 1ns / 1ps
module wav_downmix_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // file_byte[7:0]
  input  logic                         in_tlast,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  // mono_sample[16:0], status[20:17], rate_out[52:21], channels_out[54:53],
  // frames_out[86:55], zero [87]
  input  logic [wpdm_pkg::TDATA_W-1:0] out_tdata,
  input  logic                         out_tuser,  // kind[0]
  input  logic                         out_tlast,
  output int                           fail_count,
  output int                           pending,
  output int                           samples_checked,
  output int                           statuses_checked,
  output logic [15:0]                  codes_seen
);
  import wpdm_pkg::*;

  logic [31:0] rate_limit = MAX_RATE_RST;

  // Parser image.
  phase_t      ph;
  logic [31:0] cnt;
  logic [31:0] acc;
  logic [32:0] remain;
  logic [15:0] fcode;
  logic [15:0] nch;
  logic [15:0] nbits;
  logic [31:0] srate;
  logic        fmt_valid;
  logic [2:0]  fbytes;
  logic [1:0]  fpos;
  logic [31:0] nframes;
  status_t     err;

  result_t     expected_results[$];
  result_t     want;
  int          mismatches = 0;
  int          n_samples = 0;
  int          n_statuses = 0;
  logic [15:0] seen_mask = '0;

  assign fail_count       = mismatches;
  assign samples_checked  = n_samples;
  assign statuses_checked = n_statuses;
  assign codes_seen       = seen_mask;

  task automatic clear_parser();
    ph        = PH_RIFF;
    cnt       = '0;
    acc       = '0;
    remain    = '0;
    fcode     = '0;
    nch       = '0;
    nbits     = '0;
    srate     = '0;
    fmt_valid = 1'b0;
    fbytes    = '0;
    fpos      = '0;
    nframes   = '0;
    err       = ST_OK;
  endtask

  task automatic halt(input status_t code);
    err = code;
    ph  = PH_HALT;
  endtask

  task automatic finish_word(input logic [31:0] w);
    cnt = '0;
    acc = '0;
    case (ph)
      PH_RIFF: begin
        if (w == TAG_RIFF) ph = PH_RSIZE;
        else halt(ST_RIFF_TAG);
      end
      PH_RSIZE: ph = PH_WAVE;
      PH_WAVE: begin
        if (w == TAG_WAVE) ph = PH_ID;
        else halt(ST_WAVE_TAG);
      end
      PH_ID: begin
        if (w == TAG_FMT) ph = PH_SZ_FMT;
        else if (w == TAG_DATA) ph = PH_SZ_DATA;
        else ph = PH_SZ_OTHER;
      end
      PH_SZ_FMT: begin
        if (w < FMT_MIN_SIZE) begin
          halt(ST_FMT_SMALL);
        end else begin
          remain = {1'b0, w} + 33'(w[0]);
          fcode  = '0;
          nch    = '0;
          srate  = '0;
          nbits  = '0;
          ph     = PH_FMT;
        end
      end
      PH_SZ_DATA: begin
        if (!fmt_valid) begin
          halt(ST_NO_FMT);
        end else if ((fbytes == 3'd4) ? (w[1:0] != 2'd0) : w[0]) begin
          halt(ST_ALIGN);
        end else begin
          remain = {1'b0, w} + 33'(w[0]);
          cnt    = w;
          fpos   = '0;
          if (remain != 0) ph = PH_DATA;
          else ph = PH_ID;
        end
      end
      default: begin
        remain = {1'b0, w} + 33'(w[0]);
        if (remain != 0) ph = PH_SKIP;
        else ph = PH_ID;
      end
    endcase
  endtask

  task automatic take_fmt_byte(input logic [7:0] b);
    logic [31:0] k;
    k = cnt;
    if (k < 2) fcode = fcode | (16'(b) << (8 * k));
    else if (k < 4) nch = nch | (16'(b) << (8 * (k - 2)));
    else if (k < 8) srate = srate | (32'(b) << (8 * (k - 4)));
    else if (k >= 14) nbits = nbits | (16'(b) << (8 * (k - 14)));
    cnt    = k + 1;
    remain = remain - 1;
    if (cnt >= 16) begin
      cnt = '0;
      if (fcode != PCM_FORMAT) halt(ST_FMT_CODE);
      else if (nbits != PCM_BITS) halt(ST_BITS);
      else if (nch != CH_MONO && nch != CH_STEREO) halt(ST_CHANNELS);
      else if (srate == 0 || srate > rate_limit) halt(ST_RATE);
      else begin
        fmt_valid = 1'b1;
        fbytes    = 3'(nch * 2);
        if (remain != 0) ph = PH_SKIP;
        else ph = PH_ID;
      end
    end
  endtask

  // Works out what one accepted file byte causes: at most a sample, then a status.
  task automatic predict_file_byte(input logic [7:0] b, input logic eof);
    logic [16:0] s0;
    logic [16:0] s1;
    result_t     r;
    case (ph)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
        acc = acc | (32'(b) << (8 * cnt[1:0]));
        cnt = {30'd0, cnt[1:0]} + 32'd1;
        if (cnt == 4) finish_word(acc);
      end
      PH_FMT: take_fmt_byte(b);
      PH_SKIP: begin
        remain = remain - 1;
        if (remain == 0) ph = PH_ID;
      end
      PH_DATA: begin
        if (cnt > 0) begin
          cnt = cnt - 1;
          acc = acc | (32'(b) << (8 * fpos));
          if (({1'b0, fpos} + 3'd1) >= fbytes) begin
            s0 = {acc[15], acc[15:0]};
            s1 = {acc[31], acc[31:16]};
            r = '0;
            r.kind = KIND_SAMPLE;
            r.mono_sample = (fbytes == 3'd4) ? (s0 + s1) : {acc[15:0], 1'b0};
            expected_results.push_back(r);
            nframes = nframes + 1;
            fpos    = '0;
            acc     = '0;
          end else begin
            fpos = fpos + 2'd1;
          end
        end
        remain = remain - 1;
        if (remain == 0) begin
          ph  = PH_ID;
          cnt = '0;
          acc = '0;
        end
      end
      default: ;
    endcase

    if (eof) begin
      if (err == ST_OK) begin
        case (ph)
          PH_RIFF: err = ST_RIFF_TAG;
          PH_RSIZE: err = ST_RIFF_SIZE;
          PH_WAVE: err = ST_WAVE_TAG;
          PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: err = ST_CHUNK_SIZE;
          PH_FMT: err = ST_FMT_TRUNC;
          PH_SKIP: err = ST_SKIP_TRUNC;
          PH_DATA: if (cnt > 0) err = ST_DATA_TRUNC;
          default: ;
        endcase
        if (err == ST_OK && !fmt_valid) err = ST_NO_FMT;
      end
      r = '0;
      r.kind        = KIND_STATUS;
      r.status      = err;
      r.frames_out  = nframes;
      r.last_result = 1'b1;
      if (err == ST_OK) begin
        r.rate_out     = srate;
        r.channels_out = nch[1:0];
      end
      expected_results.push_back(r);
      clear_parser();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rate_limit = MAX_RATE_RST;
      clear_parser();
      expected_results.delete();
    end else begin
      if (cfg_we) rate_limit = cfg_wdata;
      if (in_tvalid && in_tready) predict_file_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting: tdata 0x%0h tuser %0b",
                 out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_tuser));
          check_field("mono_sample", {15'd0, want.mono_sample}, {15'd0, out_tdata[16:0]});
          check_field("status", 32'(want.status), 32'(out_tdata[20:17]));
          check_field("rate_out", want.rate_out, out_tdata[52:21]);
          check_field("channels_out", 32'(want.channels_out), 32'(out_tdata[54:53]));
          check_field("frames_out", want.frames_out, out_tdata[86:55]);
          check_field("last_result", 32'(want.last_result), 32'(out_tlast));
          if (want.kind == KIND_STATUS) begin
            n_statuses++;
            seen_mask[want.status] = 1'b1;
          end else begin
            n_samples++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/wav_pcm16_parser_downmix_unit_tb.sv */
// Top of the testbench: clock, reset, WAV file stimulus, flow control and verdict.
`timescale 1ns / 1ps
module wav_pcm16_parser_downmix_unit_tb;
  import wpdm_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int RANDOM_BYTES    = 800;
  localparam int LONG_HOLD       = 120;
  localparam int DRAIN_CYCLES    = 8;
  localparam logic [31:0] TAG_LIST = 32'h5453494C;
  localparam logic [15:0] EXTREME_WORDS[6] = '{16'h7FFF, 16'h7FFF, 16'h8000,
                                                16'h8000, 16'h0000, 16'hFFFF};

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [31:0]         cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [TDATA_W-1:0]  out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  int          fail_count;
  int          pending;
  int          samples_checked;
  int          statuses_checked;
  logic [15:0] codes_seen;

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          quiet = 0;
  logic [31:0] cur_limit = MAX_RATE_RST;
  int          layout_ch = 2;
  int          files_sent = 0;
  int          bytes_sent = 0;
  int          limits_used = 1;
  logic [7:0]  wav_image[$];

  wav_pcm16_parser_downmix_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  wav_downmix_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .fail_count       (fail_count),
    .pending          (pending),
    .samples_checked  (samples_checked),
    .statuses_checked (statuses_checked),
    .codes_seen       (codes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off counted here when one is requested.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = LONG_HOLD - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    wav_image.push_back(b);
  endtask

  task automatic put16(input logic [15:0] v);
    put_byte(v[7:0]);
    put_byte(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  task automatic start_file(input logic [31:0] riff_size);
    wav_image.delete();
    put32(TAG_RIFF);
    put32(riff_size);
    put32(TAG_WAVE);
  endtask

  task automatic add_fmt(input logic [31:0] size, input logic [15:0] code,
                         input logic [15:0] ch, input logic [31:0] rate,
                         input logic [15:0] bits);
    put32(TAG_FMT);
    put32(size);
    put16(code);
    put16(ch);
    put32(rate);
    put32(rate * 32'(ch) * 2);
    put16(16'(ch * 2));
    put16(bits);
    for (int i = 16; i < int'(size); i++) put_byte(8'($urandom));
    if (size >= 16 && size[0]) put_byte(8'($urandom));
  endtask

  // Sample words come, with the given odds, from a table of full-scale, zero and -1 values; others are random.
  task automatic add_data(input logic [31:0] size, input int extreme_pct);
    logic [15:0] w;
    put32(TAG_DATA);
    put32(size);
    for (int i = 0; i < int'(size); i += 2) begin
      if ($urandom_range(99) < extreme_pct) w = EXTREME_WORDS[(i / 2) % 6];
      else w = 16'($urandom);
      put_byte(w[7:0]);
      if (i + 1 < int'(size)) put_byte(w[15:8]);
    end
    if (size[0]) put_byte(8'($urandom));
  endtask

  task automatic add_other(input logic [31:0] id, input logic [31:0] size, input int body);
    put32(id);
    put32(size);
    repeat (body) put_byte(8'($urandom));
    if (body == int'(size) && size[0]) put_byte(8'($urandom));
  endtask

  task automatic random_fmt();
    int          r;
    logic [31:0] size;
    logic [15:0] code;
    logic [15:0] ch;
    logic [31:0] rate;
    logic [15:0] bits;
    r = $urandom_range(99);
    if (r < 80) size = 32'd16;
    else if (r < 90) size = $urandom_range(17, 21);
    else size = $urandom_range(0, 15);
    code = ($urandom_range(99) < 92) ? PCM_FORMAT : 16'($urandom);
    r = $urandom_range(99);
    if (r < 45) ch = CH_MONO;
    else if (r < 90) ch = CH_STEREO;
    else if (r < 94) ch = 16'd0;
    else if (r < 97) ch = 16'd3;
    else ch = 16'($urandom);
    r = $urandom_range(99);
    if (r < 60) rate = $urandom_range(1, cur_limit);
    else if (r < 72) rate = cur_limit;
    else if (r < 80) rate = (cur_limit == 32'hFFFFFFFF) ? cur_limit : cur_limit + 1;
    else if (r < 86) rate = 32'd0;
    else if (r < 94) rate = 32'd44100;
    else rate = $urandom;
    bits = ($urandom_range(99) < 92) ? PCM_BITS : 16'($urandom);
    if (ch == CH_MONO || ch == CH_STEREO) layout_ch = int'(ch);
    add_fmt(size, code, ch, rate, bits);
  endtask

  task automatic random_data();
    int          fb;
    logic [31:0] size;
    fb   = layout_ch * 2;
    size = 32'($urandom_range(0, 5) * fb);
    if ($urandom_range(99) < 8) size = size + $urandom_range(1, fb - 1);
    add_data(size, 12);
  endtask

  // Mostly well-formed files with random content; some are cut short, get a bad byte or get extra bytes at the end.
  task automatic make_random_file();
    int n_chunks;
    int r;
    int cut;
    int idx;
    layout_ch = 2;
    start_file($urandom);
    if ($urandom_range(99) < 88) random_fmt();
    n_chunks = $urandom_range(1, 3);
    repeat (n_chunks) begin
      r = $urandom_range(99);
      if (r < 55) random_data();
      else if (r < 80) add_other($urandom, $urandom_range(0, 7), 0);
      else random_fmt();
    end
    r = $urandom_range(99);
    if (r < 22) begin
      cut = $urandom_range(1, wav_image.size());
      while (wav_image.size() > cut) void'(wav_image.pop_back());
    end else if (r < 34) begin
      idx = $urandom_range(0, wav_image.size() - 1);
      wav_image[idx] = wav_image[idx] ^ 8'($urandom_range(1, 255));
    end else if (r < 42) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
    end
  endtask

  task automatic send_file_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_file();
    for (int i = 0; i < wav_image.size(); i++)
      send_file_byte(wav_image[i], i == wav_image.size() - 1);
    bytes_sent += wav_image.size();
    files_sent++;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_rate_limit(input logic [31:0] v);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_limit = v;
    limits_used++;
  endtask

  initial begin
    int phase_bytes;
    int fidx;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // End of file on the very first byte.
    wav_image.delete();
    put_byte(8'hFF);
    send_file();
    // Bad RIFF tag; later bytes are ignored until the end.
    wav_image.delete();
    put32(32'h58464952);
    put_byte(8'h00);
    send_file();
    // Mono at the highest accepted rate, full-scale, zero and -1 samples, oversized RIFF size;
    // the last byte completes a sample, so sample and status come together.
    // The receiver holds off meanwhile, so the queue fills and the input stalls.
    start_file(32'hFFFFFFFF);
    add_fmt(32'd16, PCM_FORMAT, CH_MONO, MAX_RATE_RST, PCM_BITS);
    add_data(32'd12, 100);
    hold_req = 1'b1;
    send_file();
    // Stereo: fmt with extension, odd unknown chunk with pad, two data chunks,
    // a second fmt that replaces the first, and an end inside a chunk tag.
    start_file(32'd0);
    add_fmt(32'd18, PCM_FORMAT, CH_STEREO, 32'd1, PCM_BITS);
    add_other(TAG_LIST, 32'd1, 1);
    add_data(32'd12, 100);
    add_fmt(32'd17, PCM_FORMAT, CH_STEREO, 32'd48000, PCM_BITS);
    add_data(32'd4, 0);
    put16(16'h6164);
    send_file();
    // Data before any fmt.
    start_file(32'd20);
    add_data(32'd0, 0);
    put_byte(8'h00);
    send_file();
    // Unknown chunk with the largest size, cut short.
    start_file(32'd100);
    add_fmt(32'd16, PCM_FORMAT, CH_MONO, 32'd8000, PCM_BITS);
    add_other(TAG_LIST, 32'hFFFFFFFF, 3);
    send_file();
    // Rate just above the limit.
    start_file(32'd100);
    add_fmt(32'd16, PCM_FORMAT, CH_STEREO, MAX_RATE_RST + 1, PCM_BITS);
    add_data(32'd4, 0);
    send_file();
    // Truncated stereo data: the partial frame is dropped.
    start_file(32'd100);
    add_fmt(32'd16, PCM_FORMAT, CH_STEREO, 32'd22050, PCM_BITS);
    add_data(32'd8, 50);
    repeat (2) void'(wav_image.pop_back());
    send_file();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_rate_limit(32'hFFFFFFFF);
        1: set_rate_limit(32'd1);
        2: set_rate_limit(32'd44100);
        default: set_rate_limit($urandom_range(8000, 400000));
      endcase
      tx_idle_pct  = (p == 1) ? 73 : (p == 3) ? 24 : 0;
      rx_stall_pct = (p == 2) ? 73 : (p == 3) ? 24 : 0;
      phase_bytes  = 0;
      fidx         = 0;
      while (phase_bytes < RANDOM_BYTES / 4) begin
        // The receiver holds off while the sender keeps making requests.
        if (p == 0 && fidx == 1) hold_req = 1'b1;
        // The sender pauses until every result is in.
        if (p == 3 && fidx == 2) while (pending != 0) @(negedge clk);
        make_random_file();
        phase_bytes += wav_image.size();
        send_file();
        fidx++;
      end
    end

    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d files (%0d bytes) under %0d rate limits and four flow patterns.",
             files_sent, bytes_sent, limits_used);
    $display("Checked %0d samples and %0d final statuses; status codes seen: %b.",
             samples_checked, statuses_checked, codes_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
